[rtl/ccp_pkg.sv]
// Package: shared types, register codes and reset values for the cooler/pump controller.
`default_nettype none
package ccp_pkg;

   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic [CSR_IDX_W-1:0] CSR_MARGIN_ON        = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ABSOLUTE_ON      = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MARGIN_OFF       = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_ABSOLUTE_OFF     = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_PUMP_INTERVAL_MS = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_PUMP_DURATION_MS = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_MANUAL_EXPIRY_MS = 3'd6;

   localparam logic        [9:0]  RST_MARGIN_ON        = 10'd5;
   localparam logic signed [11:0] RST_ABSOLUTE_ON      = 12'sd350;
   localparam logic        [9:0]  RST_MARGIN_OFF       = 10'd2;
   localparam logic signed [11:0] RST_ABSOLUTE_OFF     = 12'sd330;
   localparam logic        [31:0] RST_PUMP_INTERVAL_MS = 32'd20000;
   localparam logic        [31:0] RST_PUMP_DURATION_MS = 32'd10000;
   localparam logic        [31:0] RST_MANUAL_EXPIRY_MS = 32'd60000;

   typedef struct packed {
      logic        [31:0] now_ms;
      logic signed [11:0] temp_inside;
      logic signed [11:0] temp_outside;
      logic               soil_dry;
      logic               manual_set;
      logic               manual_pump_value;
   } req_type;

   typedef struct packed {
      logic cooler_run;
      logic pump_on;
      logic led_red;
      logic buzzer_on;
      logic override_active;
      logic override_expired;
   } rsp_type;

   typedef struct packed {
      logic        [9:0]  margin_on;
      logic signed [11:0] absolute_on;
      logic        [9:0]  margin_off;
      logic signed [11:0] absolute_off;
      logic        [31:0] pump_interval_ms;
      logic        [31:0] pump_duration_ms;
      logic        [31:0] manual_expiry_ms;
   } cfg_type;

   // decision of one tick, handed from the control core to the pipeline
   typedef struct packed {
      logic cooler_run;
      logic pump_on;
      logic override_active;
      logic override_expired;
   } dec_type;

endpackage
`default_nettype wire

[rtl/ccp_csr.sv]
// Configuration register file with reset values.
`default_nettype none
module ccp_csr (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            csr_write,
   input  wire logic [ccp_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire logic [ccp_pkg::CSR_DATA_W-1:0]  csr_wdata,
   output ccp_pkg::cfg_type                     cfg
);

   ccp_pkg::cfg_type cfg_ff;
   ccp_pkg::cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         case (csr_index)
            ccp_pkg::CSR_MARGIN_ON:        cfg_in.margin_on        = csr_wdata[9:0];
            ccp_pkg::CSR_ABSOLUTE_ON:      cfg_in.absolute_on      = signed'(csr_wdata[11:0]);
            ccp_pkg::CSR_MARGIN_OFF:       cfg_in.margin_off       = csr_wdata[9:0];
            ccp_pkg::CSR_ABSOLUTE_OFF:     cfg_in.absolute_off     = signed'(csr_wdata[11:0]);
            ccp_pkg::CSR_PUMP_INTERVAL_MS: cfg_in.pump_interval_ms = csr_wdata[31:0];
            ccp_pkg::CSR_PUMP_DURATION_MS: cfg_in.pump_duration_ms = csr_wdata[31:0];
            ccp_pkg::CSR_MANUAL_EXPIRY_MS: cfg_in.manual_expiry_ms = csr_wdata[31:0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.margin_on        <= ccp_pkg::RST_MARGIN_ON;
         cfg_ff.absolute_on      <= ccp_pkg::RST_ABSOLUTE_ON;
         cfg_ff.margin_off       <= ccp_pkg::RST_MARGIN_OFF;
         cfg_ff.absolute_off     <= ccp_pkg::RST_ABSOLUTE_OFF;
         cfg_ff.pump_interval_ms <= ccp_pkg::RST_PUMP_INTERVAL_MS;
         cfg_ff.pump_duration_ms <= ccp_pkg::RST_PUMP_DURATION_MS;
         cfg_ff.manual_expiry_ms <= ccp_pkg::RST_MANUAL_EXPIRY_MS;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule
`default_nettype wire

[rtl/ccp_ctrl.sv]
// Control core: cooler hysteresis, manual override and automatic watering state.
`default_nettype none
module ccp_ctrl (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              step,
   input  wire ccp_pkg::req_type  req,
   input  wire ccp_pkg::cfg_type  cfg,
   output ccp_pkg::dec_type       dec
);

   logic        cooler_ff, cooler_in;
   logic        ovr_flag_ff, ovr_flag_in;
   logic        ovr_level_ff, ovr_level_in;
   logic [31:0] ovr_stamp_ff, ovr_stamp_in;
   logic        auto_ff, auto_in;
   logic [31:0] wstart_ff, wstart_in;
   logic [31:0] wlast_ff, wlast_in;

   logic signed [12:0] diff;
   logic [31:0] ovr_age, last_age, water_age;
   logic        expired, start, stop, flag_set;

   always_comb begin
      diff = 13'(req.temp_inside) - 13'(req.temp_outside);
      if (!cooler_ff) begin
         cooler_in = (diff >= signed'({3'b000, cfg.margin_on})) ||
                     (req.temp_inside >= cfg.absolute_on);
      end else begin
         cooler_in = !((diff < signed'({3'b000, cfg.margin_off})) &&
                       (req.temp_inside < cfg.absolute_off));
      end

      // a fresh command has zero age
      ovr_age      = req.now_ms - ovr_stamp_ff;
      flag_set     = req.manual_set || ovr_flag_ff;
      expired      = req.manual_set ? (cfg.manual_expiry_ms == 32'd0)
                                    : (ovr_flag_ff && ovr_age >= cfg.manual_expiry_ms);
      ovr_flag_in  = flag_set && !expired;
      ovr_level_in = req.manual_set ? req.manual_pump_value : ovr_level_ff;
      ovr_stamp_in = req.manual_set ? req.now_ms : ovr_stamp_ff;

      // a watering that starts this tick has zero age
      last_age  = req.now_ms - wlast_ff;
      water_age = req.now_ms - wstart_ff;
      start     = !auto_ff && (last_age >= cfg.pump_interval_ms);
      stop      = start ? (cfg.pump_duration_ms == 32'd0)
                        : (auto_ff && water_age >= cfg.pump_duration_ms);
      auto_in   = (auto_ff || start) && !stop;
      wstart_in = start ? req.now_ms : wstart_ff;
      wlast_in  = start ? req.now_ms : wlast_ff;

      dec.cooler_run       = cooler_in;
      dec.pump_on          = ovr_flag_in ? ovr_level_in : auto_in;
      dec.override_active  = ovr_flag_in;
      dec.override_expired = expired;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cooler_ff    <= 1'b0;
         ovr_flag_ff  <= 1'b0;
         ovr_level_ff <= 1'b0;
         ovr_stamp_ff <= 32'd0;
         auto_ff      <= 1'b0;
         wstart_ff    <= 32'd0;
         wlast_ff     <= 32'd0;
      end else if (step) begin
         cooler_ff    <= cooler_in;
         ovr_flag_ff  <= ovr_flag_in;
         ovr_level_ff <= ovr_level_in;
         ovr_stamp_ff <= ovr_stamp_in;
         auto_ff      <= auto_in;
         wstart_ff    <= wstart_in;
         wlast_ff     <= wlast_in;
      end
   end

endmodule
`default_nettype wire

[rtl/ccp_blink.sv]
// Blink window parity: bit 0 of now_ms / BLINK_HALF_MS by exact reciprocal multiply.
`default_nettype none
module ccp_blink #(
   parameter int unsigned BLINK_HALF_MS = 500
) (
   input  wire logic        clock,
   input  wire logic        step,
   input  wire logic [31:0] now_ms,
   output logic             odd
);

   // round-up reciprocal, exact for every 32-bit dividend; fits in 33 bits
   localparam int unsigned SHIFT = 32 + $clog2(BLINK_HALF_MS);
   localparam logic [63:0] MAGIC =
      ((64'd1 << SHIFT) + 64'(BLINK_HALF_MS) - 64'd1) / 64'(BLINK_HALF_MS);

   logic [64:0] prod;
   logic        odd_ff, odd_in;

   always_comb begin
      prod   = {33'd0, now_ms} * {32'd0, MAGIC[32:0]};
      odd_in = prod[SHIFT];
   end

   always_ff @(posedge clock) begin
      if (step) begin
         odd_ff <= odd_in;
      end
   end

   assign odd = odd_ff;

endmodule
`default_nettype wire

[rtl/climate_cooler_pump_controller.sv]
// Top level: cooler/pump controller with input, decision and result registers.
//
//  channel  direction  handshake             payload
//  req      in         req_valid/req_stall   req_data  (ccp_pkg::req_type)
//  rsp      out        rsp_valid/rsp_stall   rsp_data  (ccp_pkg::rsp_type)
//  csr      in         csr_write             csr_index, csr_wdata
//
// One transaction per cycle while rsp_stall is low; an accepted request passes the
// input, decision/multiply and result registers before rsp_valid rises.
// The blink multiply (32 x 33 bits) sets the depth of the decision stage.
// Synchronous reset clears control state and valid bits; CSRs load reset values.
// Each stage holds while the one after it is full and stalled, so a transaction
// can enter while a finished result waits on rsp_stall.
`default_nettype none
module climate_cooler_pump_controller #(
   parameter int unsigned BLINK_HALF_MS = 500
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_valid,
   output logic                                 req_stall,
   input  wire ccp_pkg::req_type                req_data,
   output logic                                 rsp_valid,
   input  wire logic                            rsp_stall,
   output ccp_pkg::rsp_type                     rsp_data,
   input  wire logic                            csr_write,
   input  wire logic [ccp_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire logic [ccp_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   ccp_pkg::cfg_type cfg;
   ccp_pkg::dec_type dec;

   logic             a_v_ff, a_v_in;
   ccp_pkg::req_type a_ff;
   logic             b_v_ff, b_v_in;
   ccp_pkg::dec_type b_dec_ff;
   logic             b_dry_ff;
   logic             b_odd;
   logic             rsp_v_ff, rsp_v_in;
   ccp_pkg::rsp_type rsp_ff, rsp_in;
   logic             ld_a, ld_b, ld_c, adv_b;

   ccp_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   ccp_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .step  (adv_b),
      .req   (a_ff),
      .cfg   (cfg),
      .dec   (dec)
   );

   ccp_blink #(
      .BLINK_HALF_MS (BLINK_HALF_MS)
   ) u_blink (
      .clock  (clock),
      .step   (adv_b),
      .now_ms (a_ff.now_ms),
      .odd    (b_odd)
   );

   always_comb begin
      ld_c  = !rsp_v_ff || !rsp_stall;
      ld_b  = !b_v_ff || ld_c;
      ld_a  = !a_v_ff || ld_b;
      adv_b = ld_b && a_v_ff;

      a_v_in   = ld_a ? req_valid : a_v_ff;
      b_v_in   = ld_b ? a_v_ff : b_v_ff;
      rsp_v_in = ld_c ? b_v_ff : rsp_v_ff;

      rsp_in.cooler_run       = b_dec_ff.cooler_run;
      rsp_in.pump_on          = b_dec_ff.pump_on;
      rsp_in.led_red          = b_dry_ff;
      rsp_in.buzzer_on        = b_dry_ff && !b_odd && !b_dec_ff.pump_on;
      rsp_in.override_active  = b_dec_ff.override_active;
      rsp_in.override_expired = b_dec_ff.override_expired;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_v_ff   <= 1'b0;
         b_v_ff   <= 1'b0;
         rsp_v_ff <= 1'b0;
      end else begin
         a_v_ff   <= a_v_in;
         b_v_ff   <= b_v_in;
         rsp_v_ff <= rsp_v_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ld_a && req_valid) begin
         a_ff <= req_data;
      end
      if (adv_b) begin
         b_dec_ff <= dec;
         b_dry_ff <= a_ff.soil_dry;
      end
      if (ld_c && b_v_ff) begin
         rsp_ff <= rsp_in;
      end
   end

   assign req_stall = !ld_a;
   assign rsp_valid = rsp_v_ff;
   assign rsp_data  = rsp_ff;

   a_expired_clears: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_data.override_expired && rsp_data.override_active))
      else $error("override reported both expired and active");

   a_buzzer_quiet: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.buzzer_on |-> rsp_data.led_red && !rsp_data.pump_on)
      else $error("buzzer on while pump runs or soil is wet");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("pipeline not empty after reset");

   a_stall_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> a_v_ff && b_v_ff && rsp_valid && rsp_stall)
      else $error("input stalled with room in the pipeline");

endmodule
`default_nettype wire
